[rtl/bb_pkg.sv]
package bb_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int MAX_XFER    = 8;

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int LEN_W  = $clog2(STORE_DEPTH + 1);
    localparam int XFER_W = $clog2(MAX_XFER + 1);
    localparam int IDX_W  = (MAX_XFER > 1) ? $clog2(MAX_XFER) : 1;

    // fixed field widths
    localparam int CFG_W   = 11;
    localparam int REQ_W   = 4;
    localparam int DATA_W  = 64;
    localparam int TOTAL_W = 11;
    localparam int BYTE_W  = 8;

    localparam int LEN_RESET = (1024 < STORE_DEPTH) ? 1024 : STORE_DEPTH;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    typedef struct packed {
        logic              is_read;
        logic [XFER_W-1:0] want;
    } t_request;

    typedef struct packed {
        logic [XFER_W-1:0] grant;
        logic [LEN_W-1:0]  pos;
    } t_plan;

    typedef struct packed {
        logic              en;
        logic              is_read;
        logic [XFER_W-1:0] grant;
        logic [LEN_W-1:0]  pos;
    } t_commit;

    function automatic logic [XFER_W-1:0] min_grant(
        input logic [XFER_W-1:0] want,
        input logic [LEN_W-1:0]  lim
    );
        logic [XFER_W-1:0] res;
        if (LEN_W'(want) < lim) begin
            res = want;
        end else begin
            res = lim[XFER_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [LEN_W-1:0] clamp_len(input logic [CFG_W-1:0] v);
        logic [31:0] x;
        x = 32'(v);
        if (x == 32'd0) begin
            x = 32'd1;
        end
        if (x > 32'(STORE_DEPTH)) begin
            x = 32'(STORE_DEPTH);
        end
        return x[LEN_W-1:0];
    endfunction

endpackage

[rtl/bb_ram.sv]
module bb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bb_region.sv]
module bb_region
    import bb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  t_request           i_req,
    input  t_commit            i_commit,
    output t_plan              o_plan,
    output logic [TOTAL_W-1:0] o_total
);

    logic [LEN_W-1:0] r_start, n_start;
    logic [LEN_W-1:0] r_a_size, n_a_size;
    logic [LEN_W-1:0] r_b_size, n_b_size;
    logic [LEN_W-1:0] r_blen, n_blen;

    logic [LEN_W-1:0] w_a_end;
    logic [LEN_W-1:0] w_room;
    logic [LEN_W-1:0] w_after;
    logic [LEN_W-1:0] w_grant_l;

    assign w_a_end = r_start + r_a_size;
    assign w_room  = (r_start > r_b_size) ? (r_start - r_b_size) : '0;
    assign w_after = (r_blen > w_a_end) ? (r_blen - w_a_end) : '0;

    // placement of the next transfer
    always_comb begin
        o_plan = '0;
        if (i_req.is_read) begin
            o_plan.pos   = r_start;
            o_plan.grant = min_grant(i_req.want, r_a_size);
        end else if (r_b_size != '0) begin
            o_plan.pos   = r_b_size;
            o_plan.grant = min_grant(i_req.want, w_room);
        end else if (w_after >= r_start) begin
            o_plan.pos   = w_a_end;
            o_plan.grant = min_grant(i_req.want, w_after);
        end else begin
            o_plan.pos   = '0;
            o_plan.grant = min_grant(i_req.want, r_start);
        end
    end

    assign w_grant_l = LEN_W'(i_commit.grant);

    always_comb begin
        n_start  = r_start;
        n_a_size = r_a_size;
        n_b_size = r_b_size;
        n_blen   = r_blen;
        if (i_cfg_we) begin
            n_blen   = clamp_len(i_cfg_data);
            n_start  = '0;
            n_a_size = '0;
            n_b_size = '0;
        end else if (i_commit.en) begin
            if (i_commit.is_read) begin
                if (w_grant_l >= r_a_size) begin
                    // a drained: b moves up
                    n_start  = '0;
                    n_a_size = r_b_size;
                    n_b_size = '0;
                end else begin
                    n_start  = r_start + w_grant_l;
                    n_a_size = r_a_size - w_grant_l;
                end
            end else if (r_a_size == '0 && r_b_size == '0) begin
                n_start  = i_commit.pos;
                n_a_size = w_grant_l;
            end else if (i_commit.pos == w_a_end) begin
                n_a_size = r_a_size + w_grant_l;
            end else begin
                n_b_size = r_b_size + w_grant_l;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start  <= '0;
            r_a_size <= '0;
            r_b_size <= '0;
            r_blen   <= LEN_W'(LEN_RESET);
        end else begin
            r_start  <= n_start;
            r_a_size <= n_a_size;
            r_b_size <= n_b_size;
            r_blen   <= n_blen;
        end
    end

    assign o_total = TOTAL_W'(r_a_size + r_b_size);

endmodule

[rtl/bipartite_buffer_core.sv]
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+-------------------------------------------
// request   | in        | start && !busy         | i_req_type, i_req_len, i_write_data
// result    | out       | o_done, one cycle      | o_granted_len, o_read_data, o_committed_total
// config    | in        | i_cfg_we               | i_cfg_data (active length)
//
// an item keeps busy high through S_PLAN, which places the transfer, S_MOVE, which
// moves each byte through the single byte-wide store port, and S_FIN, which collects
// the last read byte; o_done pulses in the same cycle as busy drops
// a new item can be accepted in the same cycle as o_done
// synchronous active-low reset clears the regions and sets the active length to 1024;
// store contents stay undefined until written
// the result side has no backpressure; o_done is never held off
module bipartite_buffer_core
    import bb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [0:0]         i_req_type,
    input  logic [REQ_W-1:0]   i_req_len,
    input  logic [DATA_W-1:0]  i_write_data,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_data,
    output logic               o_done,
    output logic [REQ_W-1:0]   o_granted_len,
    output logic [DATA_W-1:0]  o_read_data,
    output logic [TOTAL_W-1:0] o_committed_total
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PLAN,
        S_MOVE,
        S_FIN
    } t_state;

    t_state            r_state;
    t_request          r_req;
    logic [DATA_W-1:0] r_wshift;     // write bytes, next one in the low byte
    logic [XFER_W-1:0] r_grant;
    logic [LEN_W-1:0]  r_pos;
    logic [XFER_W-1:0] r_cnt;        // bytes issued to the store
    logic              r_cap_valid;  // read byte arriving from the store this cycle
    logic [IDX_W-1:0]  r_cap_idx;
    logic [DATA_W-1:0] r_rdata;
    logic              r_done;
    logic [REQ_W-1:0]  r_out_grant;
    logic [DATA_W-1:0] r_out_rdata;
    logic [TOTAL_W-1:0] r_out_total;

    t_plan              w_plan;
    t_commit            w_commit;
    logic [TOTAL_W-1:0] w_total;
    logic               w_accept;
    logic               w_last;
    logic [LEN_W-1:0]   w_addr_full;
    logic [ADDR_W-1:0]  w_addr;
    logic               w_we;
    logic [BYTE_W-1:0]  w_wbyte;
    logic [BYTE_W-1:0]  w_qbyte;
    logic [DATA_W-1:0]  w_rdata;
    logic [XFER_W-1:0]  w_want;

    assign w_accept = start && !busy;
    assign busy     = (r_state != S_IDLE);

    // oversized requests are cut to the transfer limit
    assign w_want = (i_req_len > REQ_W'(MAX_XFER)) ? XFER_W'(MAX_XFER)
                                                   : i_req_len[XFER_W-1:0];

    assign w_last = (r_cnt + XFER_W'(1)) == r_grant;

    // one store access per cycle: a write byte, or a read that zeroes its byte
    assign w_addr_full = r_pos + LEN_W'(r_cnt);
    assign w_addr      = w_addr_full[ADDR_W-1:0];
    assign w_we        = (r_state == S_MOVE);
    assign w_wbyte     = (r_req.is_read == REQ_READ) ? '0 : r_wshift[BYTE_W-1:0];

    // region update lands with the last byte
    always_comb begin
        w_commit         = '0;
        w_commit.en      = (r_state == S_MOVE) && w_last;
        w_commit.is_read = r_req.is_read;
        w_commit.grant   = r_grant;
        w_commit.pos     = r_pos;
    end

    // merge the byte the store returns for the previous read access
    assign w_rdata = r_cap_valid
                   ? (r_rdata | (DATA_W'(w_qbyte) << {r_cap_idx, 3'b000}))
                   : r_rdata;

    bb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (w_wbyte),
        .i_raddr (w_addr),
        .o_rdata (w_qbyte)
    );

    bb_region u_region (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (r_req),
        .i_commit   (w_commit),
        .o_plan     (w_plan),
        .o_total    (w_total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done      <= 1'b0;
            r_cap_valid <= 1'b0;
        end else begin
            r_done      <= 1'b0;
            r_cap_valid <= 1'b0;
            r_rdata     <= w_rdata;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_req.is_read <= i_req_type[0];
                        r_req.want    <= w_want;
                        r_wshift      <= i_write_data;
                        r_rdata       <= '0;
                        r_state       <= S_PLAN;
                    end
                end
                S_PLAN: begin
                    r_grant <= w_plan.grant;
                    r_pos   <= w_plan.pos;
                    r_cnt   <= '0;
                    // nothing to move: report at once
                    r_state <= (w_plan.grant == '0) ? S_FIN : S_MOVE;
                end
                S_MOVE: begin
                    r_cnt       <= r_cnt + XFER_W'(1);
                    r_wshift    <= r_wshift >> BYTE_W;
                    r_cap_valid <= (r_req.is_read == REQ_READ);
                    r_cap_idx   <= r_cnt[IDX_W-1:0];
                    if (w_last) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_done      <= 1'b1;
                    r_out_grant <= REQ_W'(r_grant);
                    r_out_rdata <= w_rdata;
                    r_out_total <= w_total;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done            = r_done;
    assign o_granted_len     = r_out_grant;
    assign o_read_data       = r_out_rdata;
    assign o_committed_total = r_out_total;

endmodule

[rtl/bb_checker.sv]
module bb_checker
    import bb_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_done,
    input logic [REQ_W-1:0]   o_granted_len,
    input logic [DATA_W-1:0]  o_read_data,
    input logic [TOTAL_W-1:0] o_committed_total
);

    // an accepted item holds the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // a result only appears once the block has gone idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy && $past(busy)))
        else $error("result strobe outside of item completion");

    a_grant_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_granted_len <= REQ_W'(MAX_XFER)))
        else $error("granted length above transfer limit");

    a_total_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_committed_total <= TOTAL_W'(STORE_DEPTH)))
        else $error("committed total above store size");

    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_granted_len == '0) |-> (o_read_data == '0))
        else $error("read data nonzero with nothing granted");

endmodule

bind bipartite_buffer_core bb_checker u_bb_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_done            (o_done),
    .o_granted_len     (o_granted_len),
    .o_read_data       (o_read_data),
    .o_committed_total (o_committed_total)
);
